// ===== hdl/thw_pkg.sv =====
// shared constants, types and helpers for the hypothesis weighting core
package thw_pkg;

  localparam int unsigned NumHyp   = 65536;
  localparam int unsigned AddrW    = $clog2(NumHyp);
  localparam int unsigned WeightW  = 33;
  localparam int unsigned FactorW  = 16;
  localparam int unsigned TotalW   = WeightW + AddrW;
  localparam int unsigned RecipW   = 64;
  localparam int unsigned HalfW    = RecipW / 2;
  localparam int unsigned ProdW    = WeightW + HalfW;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  localparam logic [WeightW-1:0] OneQ32       = {1'b1, {(WeightW-1){1'b0}}};
  localparam logic [FactorW-1:0] FactorReset  = 16'd32768;
  localparam logic [AddrW-1:0]   LastIdx      = AddrW'(NumHyp - 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_DIV,
    ST_RESC,
    ST_RESC_WAIT,
    ST_QUERY,
    ST_QUERY_WAIT,
    ST_FINISH
  } state_e;

  // prediction of hypothesis a for trait index sel
  function automatic logic hyp_bit(input logic [AddrW-1:0] a, input logic [3:0] sel);
    logic [15:0] ext;
    ext = 16'(a);
    return ext[sel];
  endfunction

endpackage

// ===== hdl/thw_ram.sv =====
// generic single-write, single-read ram with registered read data
module thw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/thw_recip.sv =====
// restoring divider forming floor(2^64 / total), one quotient bit per cycle
module thw_recip (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [thw_pkg::TotalW-1:0] total_i,
  output logic                       done_o,
  output logic [thw_pkg::RecipW-1:0] recip_o
);
  import thw_pkg::*;

  localparam int unsigned StepW = $clog2(RecipW + 1);

  logic               busy_q;
  logic [StepW-1:0]   step_q;
  logic [TotalW:0]    rem_q;
  logic [TotalW:0]    rem_sh;
  logic [TotalW:0]    rem_sub;
  logic               qbit;
  logic [RecipW-1:0]  quot_q;
  logic               done_q;

  // numerator is a single one at the top bit position
  always_comb begin
    rem_sh  = {rem_q[TotalW-1:0], (step_q == StepW'(RecipW))};
    qbit    = (rem_sh >= {1'b0, total_i});
    rem_sub = rem_sh - {1'b0, total_i};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(RecipW);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= qbit ? rem_sub : rem_sh;
      quot_q <= {quot_q[RecipW-2:0], qbit};
    end
  end

  assign done_o  = done_q;
  assign recip_o = quot_q;

endmodule

// ===== hdl/truth_table_hypothesis_weighting_core.sv =====
// top level: multiplicative-weights core over a ram of hypothesis weights
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser action; tdata traits, label, load_index, load_value
//  m_axis   | out       | tuser status; tdata certainty
//  cfg      | in        | data penalty factor, always ready
//
// load writes one weight; query sweeps the weight ram once; update sweeps the
// N = 65536 weights through the single read port of the weight ram once for
// scaling, runs 65 steps of the bit-serial reciprocal, and sweeps a second time.
// reset clears control only; weights are undefined until loaded.
// a new beat is taken while a result waits on m_axis; a finished item holds
// until the output register is free.
module truth_table_hypothesis_weighting_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [3:0] traits, [4] label, [20:5] load_index, [53:21] load_value
  input  logic [thw_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [32:0] certainty
  output logic [thw_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] status
  output logic [0:0]                   m_axis_tuser,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [thw_pkg::FactorW-1:0]  cfg_data_i
);
  import thw_pkg::*;

  state_e               state_q, state_d;
  logic [AddrW-1:0]     cnt_q, cnt_d;
  logic [1:0]           op_q;
  logic [3:0]           sel_q;
  logic                 label_q;
  logic [15:0]          lidx_q;
  logic [WeightW-1:0]   lval_q;
  logic [FactorW-1:0]   cf_q;

  logic                 rd_v_q, s2_v_q, s3_v_q;
  logic [AddrW-1:0]     rd_addr_q, s2_addr_q, s3_addr_q;
  logic [WeightW-1:0]   s2_w_q, s3_w_q;
  logic [ProdW-1:0]     ph_q, pl_q;
  logic                 nz_q;

  logic [TotalW-1:0]    total_q, qsum_q;
  logic                 status_q, full_q;
  logic                 m_valid_q;
  logic [WeightW-1:0]   m_cert_q;
  logic                 m_status_q;

  logic                 accept, issue, pipe_empty, slot_free;
  logic                 in_scale, in_resc, in_query;
  logic                 div_start, div_done;
  logic [RecipW-1:0]    recip;
  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_waddr;
  logic [WeightW-1:0]   ram_wdata, ram_rdata;
  logic                 load_ok;
  logic [WeightW-1:0]   load_w;
  logic                 rd_bit;
  logic [WeightW+FactorW-1:0] sprod;
  logic [WeightW-1:0]   scaled_w;
  logic [ProdW:0]       asum;
  logic [WeightW-1:0]   resc_w;
  logic [WeightW-1:0]   cert_cap;

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign pipe_empty  = !rd_v_q && !s2_v_q && !s3_v_q;
  assign slot_free   = !m_valid_q || m_axis_tready;
  assign in_scale    = (state_q == ST_SCALE) || (state_q == ST_SCALE_WAIT);
  assign in_resc     = (state_q == ST_RESC) || (state_q == ST_RESC_WAIT);
  assign in_query    = (state_q == ST_QUERY) || (state_q == ST_QUERY_WAIT);
  assign issue       = (state_q == ST_SCALE) || (state_q == ST_RESC) ||
                       (state_q == ST_QUERY);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            OP_LOAD:   state_d = ST_LOAD;
            OP_UPDATE: state_d = ST_SCALE;
            OP_QUERY:  state_d = ST_QUERY;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_LOAD:       state_d = ST_FINISH;
      ST_SCALE:      if (cnt_q == LastIdx) state_d = ST_SCALE_WAIT;
      ST_SCALE_WAIT: begin
        if (pipe_empty) begin
          if (total_q == '0) begin
            state_d = ST_FINISH;
          end else if (total_q == TotalW'(1)) begin
            state_d = ST_RESC;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV:        if (div_done) state_d = ST_RESC;
      ST_RESC:       if (cnt_q == LastIdx) state_d = ST_RESC_WAIT;
      ST_RESC_WAIT:  if (pipe_empty) state_d = ST_FINISH;
      ST_QUERY:      if (cnt_q == LastIdx) state_d = ST_QUERY_WAIT;
      ST_QUERY_WAIT: if (pipe_empty) state_d = ST_FINISH;
      ST_FINISH:     if (slot_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_start     = (state_q == ST_SCALE_WAIT) && pipe_empty &&
                    (total_q > TotalW'(1));
    cnt_d         = cnt_q;
    if (issue) begin
      cnt_d = (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;
    end
  end

  // load address check and clamp
  assign load_ok = ({1'b0, lidx_q} < 17'(NumHyp));
  assign load_w  = (lval_q > OneQ32) ? OneQ32 : lval_q;

  // stage one arithmetic on read data
  always_comb begin
    rd_bit   = hyp_bit(rd_addr_q, sel_q);
    sprod    = (WeightW+FactorW)'(ram_rdata) * (WeightW+FactorW)'(cf_q);
    scaled_w = (rd_bit != label_q) ? sprod[WeightW+FactorW-1:FactorW] : ram_rdata;
  end

  // stage two rescale sum and cap
  always_comb begin
    asum = (ProdW+1)'(ph_q) + (ProdW+1)'(pl_q[ProdW-1:HalfW]);
    if (full_q) begin
      resc_w = nz_q ? OneQ32 : '0;
    end else if (asum > (ProdW+1)'(OneQ32)) begin
      resc_w = OneQ32;
    end else begin
      resc_w = asum[WeightW-1:0];
    end
  end

  assign cert_cap = (qsum_q > TotalW'(OneQ32)) ? OneQ32 : qsum_q[WeightW-1:0];

  // ram port control
  always_comb begin
    ram_re    = issue;
    ram_we    = 1'b0;
    ram_waddr = s2_addr_q;
    ram_wdata = s2_w_q;
    if (state_q == ST_LOAD) begin
      ram_we    = load_ok;
      ram_waddr = lidx_q[AddrW-1:0];
      ram_wdata = load_w;
    end else if (in_scale) begin
      ram_we = s2_v_q;
    end else if (in_resc) begin
      ram_we    = s3_v_q;
      ram_waddr = s3_addr_q;
      ram_wdata = s3_w_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cf_q      <= FactorReset;
      rd_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        cf_q <= cfg_data_i;
      end
      rd_v_q <= issue;
      s2_v_q <= rd_v_q && !in_query;
      s3_v_q <= s2_v_q && in_resc;
      if ((state_q == ST_FINISH) && slot_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // item, pipeline and accumulator registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= s_axis_tuser;
      sel_q    <= s_axis_tdata[3:0];
      label_q  <= s_axis_tdata[4];
      lidx_q   <= s_axis_tdata[20:5];
      lval_q   <= s_axis_tdata[53:21];
      total_q  <= '0;
      qsum_q   <= '0;
      status_q <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      if (in_scale && s2_v_q) begin
        total_q <= total_q + TotalW'(s2_w_q);
      end
      if (in_query && rd_v_q && rd_bit) begin
        qsum_q <= qsum_q + TotalW'(ram_rdata);
      end
      if ((state_q == ST_SCALE_WAIT) && pipe_empty) begin
        status_q <= (total_q == '0);
        full_q   <= (total_q == TotalW'(1));
      end
    end
    rd_addr_q <= cnt_q;
    s2_addr_q <= rd_addr_q;
    s3_addr_q <= s2_addr_q;
    s2_w_q    <= scaled_w;
    ph_q      <= ProdW'(ram_rdata) * ProdW'(recip[RecipW-1:HalfW]);
    pl_q      <= ProdW'(ram_rdata) * ProdW'(recip[HalfW-1:0]);
    nz_q      <= (ram_rdata != '0);
    s3_w_q    <= resc_w;
    if ((state_q == ST_FINISH) && slot_free) begin
      m_cert_q   <= (op_q == OP_QUERY) ? cert_cap : '0;
      m_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'(m_cert_q);
  assign m_axis_tuser  = m_status_q;

  // weight store
  thw_ram #(
    .WIDTH (WeightW),
    .DEPTH (NumHyp)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // reciprocal of the scaled total
  thw_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .total_i (total_q),
    .done_o  (div_done),
    .recip_o (recip)
  );

endmodule

// ===== sim/truth_table_hypothesis_weighting_core_tb.sv =====
// testbench for the hypothesis weighting core: self-checking stream stimulus and predictor
`timescale 1ns / 100ps

module truth_table_hypothesis_weighting_core_tb;
  import thw_pkg::*;

  localparam logic [1:0] OpUnused  = 2'd3;
  localparam int unsigned CycleCap = 60_000_000;
  localparam logic [32:0] MaxVal   = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic [32:0] certainty;
    logic        status;
  } result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [FactorW-1:0]   cfg_data_i = '0;

  // predictor state
  logic [32:0]  weight_mem [NumHyp];
  logic [15:0]  factor_q = FactorReset;
  result_t      expected_results [$];

  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           fast_mode = 1'b0;
  bit           long_hold = 1'b0;
  int unsigned  hold_cnt = 0;

  truth_table_hypothesis_weighting_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("truth_table_hypothesis_weighting_core_tb NOT OK");
      $finish;
    end
  end

  // multiplicative-weights update followed by renormalization
  function automatic logic reweight(input logic [3:0] tr, input logic lbl);
    logic [48:0] total;
    logic [64:0] recip;
    logic [79:0] acc;
    total = '0;
    for (int i = 0; i < NumHyp; i++) begin
      if (((i >> tr) & 1) != lbl)
        weight_mem[i] = 33'((49'(weight_mem[i]) * 49'(factor_q)) >> 16);
      total += 49'(weight_mem[i]);
    end
    if (total == 0) return 1'b1;
    recip = (65'd1 << 64) / 65'(total);
    for (int i = 0; i < NumHyp; i++) begin
      if (total == 1) begin
        weight_mem[i] = (weight_mem[i] != 0) ? OneQ32 : '0;
      end else begin
        acc = 80'(weight_mem[i]) * 80'(recip[63:32]);
        if (acc <= 80'(OneQ32))
          acc += (80'(weight_mem[i]) * 80'(recip[31:0])) >> 32;
        weight_mem[i] = (acc > 80'(OneQ32)) ? OneQ32 : acc[32:0];
      end
    end
    return 1'b0;
  endfunction

  // summed weight of hypotheses predicting true
  function automatic logic [32:0] true_weight(input logic [3:0] tr);
    logic [48:0] sum;
    sum = '0;
    for (int i = 0; i < NumHyp; i++)
      if ((i >> tr) & 1) sum += 49'(weight_mem[i]);
    return (sum > 49'(OneQ32)) ? OneQ32 : sum[32:0];
  endfunction

  function automatic result_t predict_item(input logic [1:0] act, input logic [3:0] tr,
                                           input logic lbl, input logic [15:0] idx,
                                           input logic [32:0] val);
    result_t r;
    r = '0;
    case (act)
      OP_LOAD: weight_mem[idx] = (val > OneQ32) ? OneQ32 : val;
      OP_UPDATE: r.status = reweight(tr, lbl);
      OP_QUERY: r.certainty = true_weight(tr);
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fast_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random backpressure plus requested long holds
  always @(negedge clk_i) begin
    int unsigned r;
    if (long_hold) begin
      long_hold = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready = 1'b0;
    end else if (fast_mode) begin
      m_axis_tready = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready = 1'b1;
      end else if (r < 96) begin
        m_axis_tready = 1'b0;
      end else begin
        hold_cnt = $urandom_range(5, 40);
        m_axis_tready = 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: certainty %0h status %0h",
               m_axis_tdata[32:0], m_axis_tuser[0]);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_axis_tdata[32:0] !== exp_r.certainty) begin
          $error("certainty: expected %0h actual %0h", exp_r.certainty, m_axis_tdata[32:0]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== exp_r.status) begin
          $error("status: expected %0h actual %0h", exp_r.status, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // one input beat; entered and left just after a falling edge
  task automatic send_item(input logic [1:0] act, input logic [3:0] tr, input logic lbl,
                           input logic [15:0] idx, input logic [32:0] val);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {2'b00, val, idx, lbl, tr};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_item(act, tr, lbl, idx, val));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_factor(input logic [15:0] f);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = f;
    do @(posedge clk_i); while (!cfg_ready_o);
    factor_q = f;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [32:0] rand_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return 33'($urandom_range(1, 1000));
    if (r < 90) return {1'b0, 32'($urandom())};
    if (r < 95) return OneQ32;
    return {1'b1, 32'($urandom())};
  endfunction

  // every weight written once, with a long receiver hold partway through
  task automatic test_fill_weights();
    fast_mode = 1'b1;
    for (int i = 0; i < NumHyp; i++) begin
      if (i == 1000) long_hold = 1'b1;
      send_item(OP_LOAD, 4'd0, 1'b0, 16'(i), rand_weight());
    end
    fast_mode = 1'b0;
    wait_drained();
  endtask

  // queries and updates on the default factor and on factor 0xFFFF, unused action, load above one
  task automatic test_basic_ops();
    send_item(OP_QUERY, 4'd0, 1'b0, 16'd0, '0);
    send_item(OP_QUERY, 4'd15, 1'b0, 16'd0, '0);
    send_item(OpUnused, 4'd15, 1'b1, 16'hFFFF, MaxVal);
    send_item(OP_LOAD, 4'd0, 1'b0, 16'hFFFF, MaxVal);
    send_item(OP_LOAD, 4'd0, 1'b0, 16'd0, '0);
    send_item(OP_UPDATE, 4'd0, 1'b0, 16'd0, '0);
    send_item(OP_QUERY, 4'd0, 1'b0, 16'd0, '0);
    send_item(OP_UPDATE, 4'd15, 1'b1, 16'd0, '0);
    send_item(OP_QUERY, 4'd7, 1'b0, 16'd0, '0);
    write_factor(16'hFFFF);
    send_item(OP_UPDATE, 4'd9, 1'b1, 16'd0, '0);
    send_item(OP_QUERY, 4'd9, 1'b0, 16'd0, '0);
  endtask

  // factor zero on both labels empties every weight
  task automatic test_zero_total();
    write_factor(16'd0);
    send_item(OP_UPDATE, 4'd3, 1'b0, 16'd0, '0);
    send_item(OP_UPDATE, 4'd3, 1'b1, 16'd0, '0);
    send_item(OP_QUERY, 4'd3, 1'b0, 16'd0, '0);
  endtask

  // a lone weight of one lsb renormalizes to full scale
  task automatic test_unit_total();
    write_factor(16'hFFFF);
    send_item(OP_LOAD, 4'd0, 1'b0, 16'd5, 33'd1);
    send_item(OP_UPDATE, 4'd0, 1'b1, 16'd0, '0);
    send_item(OP_QUERY, 4'd2, 1'b0, 16'd0, '0);
    send_item(OP_LOAD, 4'd0, 1'b0, 16'd7, MaxVal);
    send_item(OP_QUERY, 4'd0, 1'b0, 16'd0, '0);
  endtask

  // random mix, factor changed between batches
  task automatic test_random_mix();
    int unsigned r;
    logic [15:0] f;
    for (int n = 0; n < 100; n++) begin
      if (n % 25 == 24) begin
        r = $urandom_range(0, 3);
        f = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? FactorReset
                                                              : 16'($urandom());
        write_factor(f);
      end
      r = $urandom_range(0, 99);
      if (r < 50)
        send_item(OP_LOAD, 4'($urandom()), 1'($urandom()), 16'($urandom()), rand_weight());
      else if (r < 72)
        send_item(OP_UPDATE, 4'($urandom()), 1'($urandom()), 16'($urandom()), '0);
      else if (r < 95)
        send_item(OP_QUERY, 4'($urandom()), 1'($urandom()), 16'($urandom()), '0);
      else
        send_item(OpUnused, 4'($urandom()), 1'($urandom()), 16'($urandom()), rand_weight());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_fill_weights();
    test_basic_ops();
    test_zero_total();
    test_unit_total();
    test_random_mix();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("truth_table_hypothesis_weighting_core_tb OK");
    else
      $display("truth_table_hypothesis_weighting_core_tb NOT OK");
    $finish;
  end

endmodule
